>>> src/ibal_pkg.sv
`timescale 1ns / 1ps

package ibal_pkg;

  localparam int NAME_W   = 56;
  localparam int SIZE_W   = 4;
  localparam int IDX_W    = 3;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int DISK_W   = 7;

  typedef enum logic [1:0] {
    KIND_CREATE = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_MAP    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_EXISTS    = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_NO_ENTRY  = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_BAD_INDEX = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_CREATE,
    S_ALLOC,
    S_DEL_RD,
    S_DEL_FREE,
    S_DEL_COMMIT,
    S_MAP_CHK,
    S_MAP_RD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    accept;
    logic    scan_rd;
    logic    scan_cmp;
    logic    create;
    logic    alloc_step;
    logic    del_rd;
    logic    del_free;
    logic    del_commit;
    logic    map_rd;
    logic    load_rsp;
    status_e rsp_status;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  too_large;
    logic  hit;
    logic  scan_last;
    logic  free_slot_any;
    logic  space_ok;
    logic  alloc_done;
    logic  del_done;
    logic  idx_ok;
    logic  rsp_free;
  } sts_t;

  // Keeps the name bytes up to the first zero byte and clears the rest.
  function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
    logic [NAME_W-1:0] res;
    logic              stop;
    res  = '0;
    stop = 1'b0;
    for (int b = 0; b < NAME_W / 8; b++) begin
      if (raw[8*b +: 8] == 8'd0) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return res;
  endfunction

endpackage

>>> src/ibal_if.sv
`timescale 1ns / 1ps

interface ibal_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [ibal_pkg::NAME_W-1:0]     req_name;
  logic [ibal_pkg::SIZE_W-1:0]     req_size;
  logic [ibal_pkg::IDX_W-1:0]      block_index;

  modport source (output valid, kind, req_name, req_size, block_index, input ready);
  modport sink (input valid, kind, req_name, req_size, block_index, output ready);
endinterface

interface ibal_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [ibal_pkg::STATUS_W-1:0]   status;
  logic [ibal_pkg::SLOT_W-1:0]     entry_slot;
  logic [ibal_pkg::DISK_W-1:0]     disk_block;

  modport source (output valid, status, entry_slot, disk_block, input ready);
  modport sink (input valid, status, entry_slot, disk_block, output ready);
endinterface

>>> src/ibal_datapath.sv
`timescale 1ns / 1ps

module ibal_datapath #(
  parameter int NUM_BLOCKS      = 128,
  parameter int NUM_ENTRIES     = 16,
  parameter int MAX_FILE_BLOCKS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      kind_i,
  input  logic [ibal_pkg::NAME_W-1:0]     req_name_i,
  input  logic [ibal_pkg::SIZE_W-1:0]     req_size_i,
  input  logic [ibal_pkg::IDX_W-1:0]      block_index_i,
  input  logic                            rsp_ready_i,
  output logic                            rsp_valid_o,
  output logic [ibal_pkg::STATUS_W-1:0]   status_o,
  output logic [ibal_pkg::SLOT_W-1:0]     entry_slot_o,
  output logic [ibal_pkg::DISK_W-1:0]     disk_block_o,
  input  ibal_pkg::cmd_t                  cmd_i,
  output ibal_pkg::sts_t                  sts_o
);

  localparam int EW = $clog2(NUM_ENTRIES);
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int KW = $clog2(MAX_FILE_BLOCKS + 1);
  localparam int LD = NUM_ENTRIES * MAX_FILE_BLOCKS;
  localparam int LW = (LD > 1) ? $clog2(LD) : 1;

  ibal_pkg::kind_e               kind_q;
  logic [ibal_pkg::NAME_W-1:0]   name_q;
  logic [ibal_pkg::SIZE_W-1:0]   size_q;
  logic [ibal_pkg::IDX_W-1:0]    idx_q;

  logic [EW-1:0]          cnt_q, ent_q, free_q;
  logic                   free_found_q;
  logic [KW-1:0]          len_q, taken_q;
  logic [BW-1:0]          blk_q, free_cnt_q;
  logic [NUM_BLOCKS-1:0]  in_use_q;
  logic [NUM_ENTRIES-1:0] valid_q;

  logic [ibal_pkg::NAME_W-1:0] name_mem [NUM_ENTRIES];
  logic [KW-1:0]               len_mem  [NUM_ENTRIES];
  logic [BW-1:0]               list_mem [LD];
  logic [ibal_pkg::NAME_W-1:0] name_rd_q;
  logic [KW-1:0]               len_rd_q;
  logic [BW-1:0]               list_rd_q;

  logic                          rsp_valid_q;
  logic [ibal_pkg::STATUS_W-1:0] status_q;
  logic [ibal_pkg::SLOT_W-1:0]   slot_q;
  logic [ibal_pkg::DISK_W-1:0]   disk_q;

  logic [LW-1:0] list_addr;
  logic          blk_free;
  logic          rsp_ok;

  assign list_addr = LW'(ent_q) * LW'(MAX_FILE_BLOCKS)
                   + (cmd_i.map_rd ? LW'(idx_q) : LW'(taken_q));
  assign blk_free  = !in_use_q[blk_q];
  assign rsp_ok    = (cmd_i.rsp_status == ibal_pkg::ST_OK);

  always_comb begin
    sts_o.kind          = kind_q;
    sts_o.too_large     = 32'(size_q) > MAX_FILE_BLOCKS;
    sts_o.hit           = valid_q[cnt_q] && (name_rd_q == name_q);
    sts_o.scan_last     = (cnt_q == EW'(NUM_ENTRIES - 1));
    sts_o.free_slot_any = free_found_q || !valid_q[cnt_q];
    sts_o.space_ok      = 32'(free_cnt_q) >= 32'(size_q);
    sts_o.alloc_done    = (taken_q == KW'(size_q));
    sts_o.del_done      = (taken_q == len_q);
    sts_o.idx_ok        = 32'(idx_q) < 32'(len_q);
    sts_o.rsp_free      = !rsp_valid_q || rsp_ready_i;
  end

  // Allocation state and the response flag are the only reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= NUM_BLOCKS'(1);
      valid_q     <= '0;
      free_cnt_q  <= BW'(NUM_BLOCKS - 1);
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.create) begin
        valid_q[free_q] <= 1'b1;
      end
      if (cmd_i.del_commit) begin
        valid_q[ent_q] <= 1'b0;
      end
      if (cmd_i.alloc_step && blk_free) begin
        in_use_q[blk_q] <= 1'b1;
        free_cnt_q      <= free_cnt_q - BW'(1);
      end
      if (cmd_i.del_free && (list_rd_q != '0)) begin
        in_use_q[list_rd_q] <= 1'b0;
        free_cnt_q          <= free_cnt_q + BW'(1);
      end
      if (cmd_i.load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q       <= ibal_pkg::kind_e'(kind_i);
      name_q       <= ibal_pkg::clean_name(req_name_i);
      size_q       <= req_size_i;
      idx_q        <= block_index_i;
      cnt_q        <= '0;
      free_found_q <= 1'b0;
    end
    if (cmd_i.scan_cmp) begin
      cnt_q <= cnt_q + EW'(1);
      if (!free_found_q && !valid_q[cnt_q]) begin
        free_q       <= cnt_q;
        free_found_q <= 1'b1;
      end
      if (sts_o.hit) begin
        ent_q   <= cnt_q;
        len_q   <= len_rd_q;
        taken_q <= '0;
      end
    end
    if (cmd_i.create) begin
      ent_q   <= free_q;
      blk_q   <= BW'(1);
      taken_q <= '0;
    end
    if (cmd_i.alloc_step) begin
      blk_q <= blk_q + BW'(1);
      if (blk_free) begin
        taken_q <= taken_q + KW'(1);
      end
    end
    if (cmd_i.del_free) begin
      taken_q <= taken_q + KW'(1);
    end
    if (cmd_i.load_rsp) begin
      status_q <= cmd_i.rsp_status;
      slot_q   <= rsp_ok ? ibal_pkg::SLOT_W'(ent_q) : '0;
      disk_q   <= (rsp_ok && kind_q == ibal_pkg::KIND_MAP)
                  ? ibal_pkg::DISK_W'(list_rd_q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.create) begin
      name_mem[free_q] <= name_q;
      len_mem[free_q]  <= KW'(size_q);
    end
    if (cmd_i.scan_rd) begin
      name_rd_q <= name_mem[cnt_q];
      len_rd_q  <= len_mem[cnt_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.alloc_step && blk_free) begin
      list_mem[list_addr] <= blk_q;
    end
    if (cmd_i.del_rd || cmd_i.map_rd) begin
      list_rd_q <= list_mem[list_addr];
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign status_o     = status_q;
  assign entry_slot_o = slot_q;
  assign disk_block_o = disk_q;

endmodule

>>> src/ibal_ctrl.sv
`timescale 1ns / 1ps

module ibal_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  ibal_pkg::sts_t sts_i,
  output ibal_pkg::cmd_t cmd_o
);

  ibal_pkg::state_e  state_q, state_d;
  ibal_pkg::status_e status_q, status_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ibal_pkg::S_IDLE;
      status_q <= ibal_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d           = state_q;
    status_d          = status_q;
    cmd_o             = '0;
    cmd_o.rsp_status  = status_q;
    req_ready_o       = 1'b0;
    unique case (state_q)
      ibal_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ibal_pkg::S_CHECK;
        end
      end
      ibal_pkg::S_CHECK: begin
        if (sts_i.kind == ibal_pkg::KIND_NONE) begin
          status_d = ibal_pkg::ST_NOT_FOUND;
          state_d  = ibal_pkg::S_RESP;
        end else if (sts_i.kind == ibal_pkg::KIND_CREATE && sts_i.too_large) begin
          status_d = ibal_pkg::ST_TOO_LARGE;
          state_d  = ibal_pkg::S_RESP;
        end else begin
          state_d = ibal_pkg::S_SCAN_RD;
        end
      end
      ibal_pkg::S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ibal_pkg::S_SCAN_CMP;
      end
      ibal_pkg::S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        if (sts_i.hit) begin
          unique case (sts_i.kind)
            ibal_pkg::KIND_CREATE: begin
              status_d = ibal_pkg::ST_EXISTS;
              state_d  = ibal_pkg::S_RESP;
            end
            ibal_pkg::KIND_DELETE: state_d = ibal_pkg::S_DEL_RD;
            default:               state_d = ibal_pkg::S_MAP_CHK;
          endcase
        end else if (!sts_i.scan_last) begin
          state_d = ibal_pkg::S_SCAN_RD;
        end else if (sts_i.kind != ibal_pkg::KIND_CREATE) begin
          status_d = ibal_pkg::ST_NOT_FOUND;
          state_d  = ibal_pkg::S_RESP;
        end else if (!sts_i.space_ok) begin
          status_d = ibal_pkg::ST_NO_SPACE;
          state_d  = ibal_pkg::S_RESP;
        end else if (!sts_i.free_slot_any) begin
          status_d = ibal_pkg::ST_NO_ENTRY;
          state_d  = ibal_pkg::S_RESP;
        end else begin
          state_d = ibal_pkg::S_CREATE;
        end
      end
      ibal_pkg::S_CREATE: begin
        cmd_o.create = 1'b1;
        state_d      = ibal_pkg::S_ALLOC;
      end
      ibal_pkg::S_ALLOC: begin
        if (sts_i.alloc_done) begin
          status_d = ibal_pkg::ST_OK;
          state_d  = ibal_pkg::S_RESP;
        end else begin
          cmd_o.alloc_step = 1'b1;
        end
      end
      ibal_pkg::S_DEL_RD: begin
        if (sts_i.del_done) begin
          state_d = ibal_pkg::S_DEL_COMMIT;
        end else begin
          cmd_o.del_rd = 1'b1;
          state_d      = ibal_pkg::S_DEL_FREE;
        end
      end
      ibal_pkg::S_DEL_FREE: begin
        cmd_o.del_free = 1'b1;
        state_d        = ibal_pkg::S_DEL_RD;
      end
      ibal_pkg::S_DEL_COMMIT: begin
        cmd_o.del_commit = 1'b1;
        status_d         = ibal_pkg::ST_OK;
        state_d          = ibal_pkg::S_RESP;
      end
      ibal_pkg::S_MAP_CHK: begin
        if (sts_i.idx_ok) begin
          state_d = ibal_pkg::S_MAP_RD;
        end else begin
          status_d = ibal_pkg::ST_BAD_INDEX;
          state_d  = ibal_pkg::S_RESP;
        end
      end
      ibal_pkg::S_MAP_RD: begin
        cmd_o.map_rd = 1'b1;
        status_d     = ibal_pkg::ST_OK;
        state_d      = ibal_pkg::S_RESP;
      end
      ibal_pkg::S_RESP: begin
        if (sts_i.rsp_free) begin
          cmd_o.load_rsp = 1'b1;
          state_d        = ibal_pkg::S_IDLE;
        end
      end
      default: state_d = ibal_pkg::S_IDLE;
    endcase
  end

endmodule

>>> src/inode_block_allocator_top.sv
`timescale 1ns / 1ps
// From acceptance to response valid: an unknown kind or an oversized create is answered without a scan,
// a lookup error, a bad index or a map after the entry scan, a delete after the scan and a walk of the
// file's block list, and a create after the scan and a walk of the bitmap for free blocks.
// One transaction at a time: the next is accepted at the earliest in the cycle after the response
// is loaded, and a stalled sink holds back the loading of each response.
// Reset clears the bitmap (block 0 stays reserved), all entry valid bits and the response flag.

module inode_block_allocator_top #(
  parameter int NUM_BLOCKS      = 128,
  parameter int NUM_ENTRIES     = 16,
  parameter int MAX_FILE_BLOCKS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  ibal_req_if.sink   req_i,
  ibal_rsp_if.source rsp_o
);

  // The controller sequences each transaction; the datapath holds the
  // entry table, the block lists, the free-block bitmap and the result register.
  ibal_pkg::cmd_t cmd;
  ibal_pkg::sts_t sts;

  ibal_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The result register lets a new request be taken while the previous
  // response still waits for the sink.
  ibal_datapath #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .NUM_ENTRIES     (NUM_ENTRIES),
    .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kind_i        (req_i.kind),
    .req_name_i    (req_i.req_name),
    .req_size_i    (req_i.req_size),
    .block_index_i (req_i.block_index),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .status_o      (rsp_o.status),
    .entry_slot_o  (rsp_o.entry_slot),
    .disk_block_o  (rsp_o.disk_block),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

>>> src/ibal_checker.sv
`timescale 1ns / 1ps

module ibal_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [ibal_pkg::STATUS_W-1:0] status_i,
  input logic [ibal_pkg::SLOT_W-1:0]   entry_slot_i,
  input logic [ibal_pkg::DISK_W-1:0]   disk_block_i
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i)
      && $stable(entry_slot_i) && $stable(disk_block_i))
    else $error("response changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while one is in progress");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i != ibal_pkg::ST_OK |-> entry_slot_i == '0 && disk_block_i == '0)
    else $error("error response carries a slot or block");

  a_disk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && disk_block_i != '0 |-> status_i == ibal_pkg::ST_OK)
    else $error("disk block given without success");

endmodule

bind inode_block_allocator_top ibal_checker u_ibal_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .entry_slot_i (rsp_o.entry_slot),
  .disk_block_i (rsp_o.disk_block)
);
